### rtl/qsed_pkg.sv
// qsed_pkg: types, character codes and the \x hex parser for the quoted
// string escape decoder. No dependencies; imported by every qsed module.
`timescale 1ns / 1ps
`default_nettype none

package qsed_pkg;

    // decode phases
    typedef enum logic [2:0] {
        PH_OPEN = 3'd0,
        PH_BODY = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX1 = 3'd3,
        PH_HEX2 = 3'd4
    } t_phase;

    localparam int          LEN_OUT_W = 16;
    localparam logic [7:0]  CH_QUOTE  = 8'h22;
    localparam logic [7:0]  CH_BSLASH = 8'h5C;
    localparam logic [7:0]  CH_X      = 8'h78;
    localparam logic [7:0]  CH_T      = 8'h74;
    localparam logic [7:0]  CH_R      = 8'h72;
    localparam logic [7:0]  CH_N      = 8'h6E;
    localparam logic [7:0]  CH_PLUS   = 8'h2B;
    localparam logic [7:0]  CH_MINUS  = 8'h2D;
    localparam logic [7:0]  CODE_TAB  = 8'h09;
    localparam logic [7:0]  CODE_CR   = 8'h0D;
    localparam logic [7:0]  CODE_LF   = 8'h0A;

    // one decoded word headed for the output stage
    typedef struct packed {
        logic                 valid;
        logic [7:0]           data_byte;
        logic                 eos;
        logic [LEN_OUT_W-1:0] len;
    } t_result;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

    // hex digit value; bit 4 set when the byte is a digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, c[3:0]};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c[3:0] + 4'd9)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c[3:0] + 4'd9)};
        return r;
    endfunction

    // base 16 parse of the two bytes after \x, result modulo 256
    function automatic logic [7:0] parse_hex2(input logic [7:0] c0, input logic [7:0] c1);
        logic [4:0] d0;
        logic [4:0] d1;
        logic [7:0] v;
        d0 = hex_digit(c0);
        d1 = hex_digit(c1);
        v  = 8'd0;
        // a zero first byte ends the string and yields zero in every branch
        if (is_space(c0)) begin
            if (d1[4]) v = {4'd0, d1[3:0]};
        end else if (is_sign(c0)) begin
            if (d1[4]) v = {4'd0, d1[3:0]};
            if (c0 == CH_MINUS) v = 8'(8'd0 - v);
        end else if (d0[4]) begin
            v = d1[4] ? {d0[3:0], d1[3:0]} : {4'd0, d0[3:0]};
        end
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/qsed_decode.sv
// qsed_decode: escape state machine, held hex byte and length counter.
// Depends on qsed_pkg; produces at most one result word per accepted byte.
`timescale 1ns / 1ps
`default_nettype none

module qsed_decode
    import qsed_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_char,
    output t_result         o_res
);

    t_phase                 r_phase, n_phase;
    logic [7:0]             r_held, n_held;
    logic [LENGTH_BITS-1:0] r_count, n_count;
    logic [LEN_OUT_W-1:0]   w_len_sat;
    logic                   w_emit;
    logic [7:0]             w_emit_byte;

    // length as seen on the end marker, saturated to the output width
    generate
        if (LENGTH_BITS > LEN_OUT_W) begin : g_sat
            always_comb begin
                w_len_sat = (|r_count[LENGTH_BITS-1:LEN_OUT_W]) ? '1
                                                                : r_count[LEN_OUT_W-1:0];
            end
        end else begin : g_ext
            always_comb begin
                w_len_sat = LEN_OUT_W'(r_count);
            end
        end
    endgenerate

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_OPEN;
            r_held  <= 8'd0;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_count <= n_count;
        end
    end

    // next state and result
    always_comb begin
        n_phase         = r_phase;
        n_held          = r_held;
        n_count         = r_count;
        w_emit          = 1'b0;
        w_emit_byte     = i_char;
        o_res.valid     = 1'b0;
        o_res.data_byte = 8'd0;
        o_res.eos       = 1'b0;
        o_res.len       = '0;
        if (i_accept) begin
            unique case (r_phase)
                PH_BODY: begin
                    if (i_char == CH_QUOTE) begin
                        o_res.valid = 1'b1;
                        o_res.eos   = 1'b1;
                        o_res.len   = w_len_sat;
                        n_count     = '0;
                        n_phase     = PH_OPEN;
                    end else if (i_char == CH_BSLASH) begin
                        n_phase = PH_ESC;
                    end else begin
                        w_emit = 1'b1;
                    end
                end
                PH_ESC: begin
                    priority if (i_char == CH_X) begin
                        n_phase = PH_HEX1;
                    end else begin
                        w_emit = 1'b1;
                        if (i_char == CH_T)      w_emit_byte = CODE_TAB;
                        else if (i_char == CH_R) w_emit_byte = CODE_CR;
                        else if (i_char == CH_N) w_emit_byte = CODE_LF;
                    end
                end
                PH_HEX1: begin
                    n_held  = i_char;
                    n_phase = PH_HEX2;
                end
                PH_HEX2: begin
                    w_emit      = 1'b1;
                    w_emit_byte = parse_hex2(r_held, i_char);
                end
                default: begin
                    // opening delimiter, dropped unchecked
                    n_count = '0;
                    n_phase = PH_BODY;
                end
            endcase
            if (w_emit) begin
                o_res.valid     = 1'b1;
                o_res.data_byte = w_emit_byte;
                n_phase         = PH_BODY;
                if (r_count != '1) n_count = r_count + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/qsed_out_stage.sv
// qsed_out_stage: output register with a skid register behind it, so a byte
// can be taken every cycle until the skid is full. Depends on qsed_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qsed_out_stage
    import qsed_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_result  i_res,
    output logic          o_ready,
    output t_result       o_head,
    input  wire logic     i_pop
);

    logic    r_out_vld, r_skid_vld;
    t_result r_out, r_skid;
    logic    w_pop;

    assign o_ready = !r_skid_vld;
    assign w_pop   = i_pop && r_out_vld;

    always_comb begin
        o_head       = r_out;
        o_head.valid = r_out_vld;
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_pop) begin
            if (r_skid_vld) begin
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= i_res.valid;
            end
        end else if (i_res.valid) begin
            if (r_out_vld) r_skid_vld <= 1'b1;
            else           r_out_vld  <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_skid_vld)       r_out <= r_skid;
            else if (i_res.valid) r_out <= i_res;
        end else if (i_res.valid) begin
            if (r_out_vld) r_skid <= i_res;
            else           r_out  <= i_res;
        end
    end

endmodule

`default_nettype wire

### rtl/quoted_string_escape_decoder.sv
// quoted_string_escape_decoder: top level, stream ports around the decoder
// and output stage. Depends on qsed_pkg, qsed_decode and qsed_out_stage.
//
// Usage: raw bytes of double-quoted literals enter on the s_axis side, one
// byte per word. The first byte of each literal is the opening delimiter and
// is dropped. Decoded characters leave on the m_axis side with tlast low;
// the closing quote yields a word with tlast high, data byte zero and the
// decoded length (saturating at 65535) in the upper tdata bits.
// Escape bytes and the first hex digit of \x give no output word.
// Result words are registered in the output stage, or in the skid register
// while the head waits, before they reach m_axis. Throughput: one byte per
// cycle while s_axis_tready is high; the state machine steps once per byte.
// Stalls: an output register plus a skid register absorb one extra word, so
// s_axis_tready drops only when both are full; nothing is lost.
// Reset (i_rst_n low, synchronous) empties the output stage and returns the
// decoder to waiting for an opening delimiter with a zero length count.
`timescale 1ns / 1ps
`default_nettype none

module quoted_string_escape_decoder
    import qsed_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_in
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [7:0] decoded_byte, [23:8] decoded_length
    output logic             m_axis_tlast    // end_of_string
);

    t_result w_res;
    t_result w_head;
    logic    w_accept;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    qsed_decode #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_char   (s_axis_tdata),
        .o_res    (w_res)
    );

    qsed_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (w_res),
        .o_ready (s_axis_tready),
        .o_head  (w_head),
        .i_pop   (m_axis_tready)
    );

    // output word packing
    assign m_axis_tvalid = w_head.valid;
    assign m_axis_tdata  = {w_head.len, w_head.data_byte};
    assign m_axis_tlast  = w_head.eos;

endmodule

`default_nettype wire
